// ===== hdl/bld_pkg.sv =====
// Shared types and constants for the block-linear deswizzle address generator.
// No dependencies.
`timescale 1ns / 1ps

package bld_pkg;

  localparam int unsigned MaxDim = 16384;

  localparam int unsigned SizeW  = 15;
  localparam int unsigned CoordW = 14;
  localparam int unsigned RobW   = 28;
  localparam int unsigned SrcW   = 34;
  localparam int unsigned DstW   = 32;

  localparam logic [2:0] CFG_TEX_WIDTH       = 3'd0;
  localparam logic [2:0] CFG_TEX_HEIGHT      = 3'd1;
  localparam logic [2:0] CFG_BLOCK_DIM       = 3'd2;
  localparam logic [2:0] CFG_BYTES_LOG2      = 3'd3;
  localparam logic [2:0] CFG_GOB_HEIGHT_LOG2 = 3'd4;

  typedef struct packed {
    logic [SizeW-1:0] wb;
    logic [SizeW-1:0] hb;
    logic [2:0]       bl;
    logic [2:0]       gl;
    logic [RobW-1:0]  rob;
  } geom_t;

  typedef struct packed {
    logic              oor;
    logic [CoordW-1:0] x;
    logic [17:0]       x1;
    logic [CoordW-1:0] y;
  } fe_item_t;

  typedef struct packed {
    logic [SrcW-1:0] src;
    logic [DstW-1:0] dst;
    logic            oor;
  } result_t;

endpackage

// ===== hdl/block_linear_deswizzle_address_top.sv =====
// Block-linear (GOB-tiled) deswizzle address generator, top level.
// Depends on bld_pkg, bld_cfg, bld_front, bld_fifo, bld_back.
//
// Usage:
//  - Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i write
//    one register per beat (0 width, 1 height, 2 block dim, 3 bytes log2,
//    4 GOB height log2). cfg_ready_o is always high. Write only while idle.
//  - After reset and after every config write the geometry sequencer runs:
//    a load step and a restoring divide each for width and height, block
//    height reduction and a final step. full stays high during that time.
//  - Input: a coordinate beat (col_i, row_i) is taken when push is high and
//    full low. One beat per cycle is sustained while pop keeps up.
//  - Output: while empty is low the oldest result sits on source_offset_o,
//    dest_offset_o and out_of_range_o; pop takes it.
//  - Path: an input beat is registered in the front stage, then passes the
//    middle queue, the back multiply stage and the output queue.
//  - Throughput is one item per cycle, set by the combinational 14x28 and
//    14x15 multiplies of the back stage. When pop is held low the queues fill
//    and full rises; nothing is dropped.
`timescale 1ns / 1ps

module block_linear_deswizzle_address_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [13:0] col_i,
  input  logic [13:0] row_i,
  output logic        empty,
  input  logic        pop,
  output logic [33:0] source_offset_o,
  output logic [31:0] dest_offset_o,
  output logic        out_of_range_o
);

  bld_pkg::geom_t    geom;
  logic              busy;
  logic              mq_push, mq_full, mq_pop, mq_empty;
  bld_pkg::fe_item_t mq_in, mq_out;
  logic              rq_push, rq_full;
  bld_pkg::result_t  rq_in, rq_out;

  bld_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom),
    .busy_o      (busy)
  );

  bld_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .col_i    (col_i),
    .row_i    (row_i),
    .geom_i   (geom),
    .busy_i   (busy),
    .q_push_o (mq_push),
    .q_item_o (mq_in),
    .q_full_i (mq_full)
  );

  bld_fifo #(
    .Width ($bits(bld_pkg::fe_item_t)),
    .Depth (2)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mq_push),
    .data_i  (mq_in),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .data_o  (mq_out),
    .empty_o (mq_empty)
  );

  bld_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (mq_empty),
    .q_item_i  (mq_out),
    .q_pop_o   (mq_pop),
    .geom_i    (geom),
    .r_push_o  (rq_push),
    .r_data_o  (rq_in),
    .r_full_i  (rq_full)
  );

  bld_fifo #(
    .Width ($bits(bld_pkg::result_t)),
    .Depth (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_in),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_out),
    .empty_o (empty)
  );

  assign source_offset_o = rq_out.src;
  assign dest_offset_o   = rq_out.dst;
  assign out_of_range_o  = rq_out.oor;

endmodule

// ===== hdl/bld_fifo.sv =====
// Small first-word-fall-through queue on flops.
// No dependencies.
`timescale 1ns / 1ps

module bld_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/bld_cfg.sv =====
// Configuration registers and the sequencer that derives image geometry from them.
// Depends on bld_pkg.
`timescale 1ns / 1ps

module bld_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [14:0]           cfg_data_i,
  output bld_pkg::geom_t        geom_o,
  output logic                  busy_o
);

  localparam logic [2:0] SEQ_IDLE = 3'd0;
  localparam logic [2:0] SEQ_LDW  = 3'd1;
  localparam logic [2:0] SEQ_DIVW = 3'd2;
  localparam logic [2:0] SEQ_LDH  = 3'd3;
  localparam logic [2:0] SEQ_DIVH = 3'd4;
  localparam logic [2:0] SEQ_RED  = 3'd5;
  localparam logic [2:0] SEQ_FIN  = 3'd6;

  localparam int unsigned SizeW = bld_pkg::SizeW;

  logic [SizeW-1:0] tex_width_q, tex_height_q;
  logic [2:0]       block_dim_q, bytes_log2_q, gob_height_log2_q;
  logic [2:0]       state_q, state_d;
  logic [SizeW-1:0] div_num_q;
  logic [2:0]       div_rem_q;
  logic [3:0]       cnt_q;
  logic [SizeW-1:0] wb_q, hb_q;
  logic [2:0]       gl_q, bl_q;
  logic [bld_pkg::RobW-1:0] rob_q;

  logic             wr;
  logic [SizeW-1:0] tw_sat, th_sat;
  logic [2:0]       bd_eff, bl_sat, gl_sat;
  logic [3:0]       rem_sh;
  logic             ge;
  logic [2:0]       rem_n;
  logic             div_last;
  logic [18:0]      wbs;
  logic [12:0]      gw;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;
  assign busy_o      = (state_q != SEQ_IDLE);

  assign tw_sat = (tex_width_q > SizeW'(bld_pkg::MaxDim)) ? SizeW'(bld_pkg::MaxDim) : tex_width_q;
  assign th_sat = (tex_height_q > SizeW'(bld_pkg::MaxDim)) ? SizeW'(bld_pkg::MaxDim)
                                                          : tex_height_q;
  assign bd_eff = (block_dim_q == 3'd0) ? 3'd1 : block_dim_q;
  assign bl_sat = (bytes_log2_q > 3'd4) ? 3'd4 : bytes_log2_q;
  assign gl_sat = (gob_height_log2_q > 3'd5) ? 3'd5 : gob_height_log2_q;

  // restoring divide, one quotient bit per cycle
  assign rem_sh   = {div_rem_q, div_num_q[SizeW-1]};
  assign ge       = (rem_sh >= {1'b0, bd_eff});
  assign rem_n    = ge ? 3'(rem_sh - {1'b0, bd_eff}) : rem_sh[2:0];
  assign div_last = (cnt_q == 4'(SizeW - 1));

  assign wbs = 19'(wb_q) << bl_sat;
  assign gw  = 13'((20'(wbs) + 20'd63) >> 6);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: state_d = SEQ_IDLE;
      SEQ_LDW:  state_d = SEQ_DIVW;
      SEQ_DIVW: if (div_last) state_d = SEQ_LDH;
      SEQ_LDH:  state_d = SEQ_DIVH;
      SEQ_DIVH: if (div_last) state_d = SEQ_RED;
      SEQ_RED: begin
        if (!((gl_q != 3'd0) && ((SizeW'(4) << gl_q) >= hb_q))) state_d = SEQ_FIN;
      end
      SEQ_FIN:  state_d = SEQ_IDLE;
      default:  state_d = SEQ_IDLE;
    endcase
    if (wr) state_d = SEQ_LDW;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= SEQ_LDW;
      tex_width_q       <= 15'd256;
      tex_height_q      <= 15'd256;
      block_dim_q       <= 3'd4;
      bytes_log2_q      <= 3'd3;
      gob_height_log2_q <= 3'd4;
    end else begin
      state_q <= state_d;
      if (wr) begin
        unique case (cfg_index_i)
          bld_pkg::CFG_TEX_WIDTH:       tex_width_q       <= cfg_data_i;
          bld_pkg::CFG_TEX_HEIGHT:      tex_height_q      <= cfg_data_i;
          bld_pkg::CFG_BLOCK_DIM:       block_dim_q       <= cfg_data_i[2:0];
          bld_pkg::CFG_BYTES_LOG2:      bytes_log2_q      <= cfg_data_i[2:0];
          bld_pkg::CFG_GOB_HEIGHT_LOG2: gob_height_log2_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SEQ_LDW: begin
        div_num_q <= SizeW'(tw_sat + SizeW'(bd_eff) - SizeW'(1));
        div_rem_q <= '0;
        cnt_q     <= '0;
        gl_q      <= gl_sat;
      end
      SEQ_LDH: begin
        div_num_q <= SizeW'(th_sat + SizeW'(bd_eff) - SizeW'(1));
        div_rem_q <= '0;
        cnt_q     <= '0;
      end
      SEQ_DIVW, SEQ_DIVH: begin
        div_num_q <= {div_num_q[SizeW-2:0], ge};
        div_rem_q <= rem_n;
        cnt_q     <= cnt_q + 4'd1;
        if (div_last) begin
          if (state_q == SEQ_DIVW) wb_q <= {div_num_q[SizeW-2:0], ge};
          else hb_q <= {div_num_q[SizeW-2:0], ge};
        end
      end
      SEQ_RED: begin
        if ((gl_q != 3'd0) && ((SizeW'(4) << gl_q) >= hb_q)) gl_q <= gl_q - 3'd1;
      end
      SEQ_FIN: begin
        bl_q  <= bl_sat;
        rob_q <= bld_pkg::RobW'(gw) << (4'd9 + 4'(gl_q));
      end
      default: ;
    endcase
  end

  assign geom_o.wb  = wb_q;
  assign geom_o.hb  = hb_q;
  assign geom_o.bl  = bl_q;
  assign geom_o.gl  = gl_q;
  assign geom_o.rob = rob_q;

endmodule

// ===== hdl/bld_front.sv =====
// Front end: accepts coordinates, flags out-of-range ones, stages them for the back end.
// Depends on bld_pkg.
`timescale 1ns / 1ps

module bld_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [13:0]         col_i,
  input  logic [13:0]         row_i,
  input  bld_pkg::geom_t      geom_i,
  input  logic                busy_i,
  output logic                q_push_o,
  output bld_pkg::fe_item_t   q_item_o,
  input  logic                q_full_i
);

  logic              fe_v_q;
  bld_pkg::fe_item_t fe_item_q;
  logic              stage_ready, accept;

  assign stage_ready = !fe_v_q || !q_full_i;
  assign full_o      = busy_i || !stage_ready;
  assign accept      = push_i && !full_o;
  assign q_push_o    = fe_v_q;
  assign q_item_o    = fe_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_v_q <= 1'b0;
    end else if (stage_ready) begin
      fe_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fe_item_q.oor <= ({1'b0, col_i} >= geom_i.wb) || ({1'b0, row_i} >= geom_i.hb);
      fe_item_q.x   <= col_i;
      fe_item_q.x1  <= 18'(col_i) << geom_i.bl;
      fe_item_q.y   <= row_i;
    end
  end

endmodule

// ===== hdl/bld_back.sv =====
// Back end: multiplies out row-of-blocks and linear row terms, then sums the offsets.
// Depends on bld_pkg.
`timescale 1ns / 1ps

module bld_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  bld_pkg::fe_item_t   q_item_i,
  output logic                q_pop_o,
  input  bld_pkg::geom_t      geom_i,
  output logic                r_push_o,
  output bld_pkg::result_t    r_data_o,
  input  logic                r_full_i
);

  logic        s1_v_q;
  logic [33:0] psrc_q;
  logic [26:0] xterm_q;
  logic [14:0] lo_q;
  logic [28:0] pdst_q;
  logic [13:0] x_q;
  logic        oor_q;

  logic        s1_ready;
  logic [13:0] ys, ymask;
  logic [41:0] psrc_full;
  logic [14:0] lo;
  logic [29:0] lin;

  assign s1_ready = !s1_v_q || !r_full_i;
  assign q_pop_o  = !q_empty_i && s1_ready;

  assign ys        = q_item_i.y >> (4'd3 + 4'(geom_i.gl));
  assign psrc_full = 42'(ys) * 42'(geom_i.rob);
  assign ymask     = q_item_i.y & 14'((16'd8 << geom_i.gl) - 16'd1);
  assign lo = (15'(ymask >> 3) << 9) + (15'(q_item_i.x1[5]) << 8)
            + (15'(q_item_i.y[2:1]) << 6) + (15'(q_item_i.x1[4]) << 5)
            + (15'(q_item_i.y[0]) << 4) + 15'(q_item_i.x1[3:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= q_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      psrc_q  <= psrc_full[33:0];
      xterm_q <= 27'(q_item_i.x1[17:6]) << (4'd9 + 4'(geom_i.gl));
      lo_q    <= lo;
      pdst_q  <= 29'(q_item_i.y) * 29'(geom_i.wb);
      x_q     <= q_item_i.x;
      oor_q   <= q_item_i.oor;
    end
  end

  assign lin      = 30'(pdst_q) + 30'(x_q);
  assign r_push_o = s1_v_q;

  always_comb begin
    r_data_o.oor = oor_q;
    if (oor_q) begin
      r_data_o.src = '0;
      r_data_o.dst = '0;
    end else begin
      r_data_o.src = psrc_q + 34'(xterm_q) + 34'(lo_q);
      r_data_o.dst = 32'(34'(lin) << geom_i.bl);
    end
  end

endmodule
